@@ src/cps_pkg.sv @@
// Shared types, codes and reset constants of the circulation pump scheduler.
`default_nettype none
package cps_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_LOCK = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_RUN_REQ  = 2'd1,
        KIND_STOP_REQ = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_RUN_DURATION   = 3'd0,
        REG_LOCKOUT        = 3'd1,
        REG_WINDOW_START   = 3'd2,
        REG_WINDOW_END     = 3'd3,
        REG_DAY_START      = 3'd4,
        REG_HYGIENE_INTVL  = 3'd5
    } reg_index_t;

    localparam int MS_W    = 27;
    localparam int HOUR_W  = 5;
    localparam int INTVL_W = 20;
    localparam int DAY_W   = 9;
    localparam int CFG_DATA_W = 27;
    localparam int CFG_INDEX_W = 3;
    localparam int IN_TDATA_W = 80;
    localparam int OUT_TDATA_W = 8;

    localparam logic [MS_W-1:0]    RESET_RUN_DURATION  = 27'd300000;
    localparam logic [MS_W-1:0]    RESET_LOCKOUT       = 27'd1800000;
    localparam logic [HOUR_W-1:0]  RESET_WINDOW_START  = 5'd6;
    localparam logic [HOUR_W-1:0]  RESET_WINDOW_END    = 5'd22;
    localparam logic [HOUR_W-1:0]  RESET_DAY_START     = 5'd6;
    localparam logic [INTVL_W-1:0] RESET_HYGIENE_INTVL = 20'd28800;

    typedef struct packed {
        logic [MS_W-1:0]    run_duration_ms;
        logic [MS_W-1:0]    lockout_ms;
        logic [HOUR_W-1:0]  window_start_hour;
        logic [HOUR_W-1:0]  window_end_hour;
        logic [HOUR_W-1:0]  day_start_hour;
        logic [INTVL_W-1:0] hygiene_interval_s;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       mono_ms;
        logic [31:0]       wall_seconds;
        logic [HOUR_W-1:0] hour;
        logic [DAY_W-1:0]  day_of_year;
        logic              clock_synced;
    } item_t;

    typedef struct packed {
        logic       request_accepted;
        logic       pump_on;
        logic [1:0] mode;
        logic       run_started;
        logic       run_stopped;
    } result_t;

endpackage
`default_nettype wire

@@ src/cps_cfg.sv @@
// Configuration register file of the circulation pump scheduler.
`default_nettype none
module cps_cfg
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [cps_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  wire logic [cps_pkg::CFG_DATA_W-1:0]    wr_data,
    output cps_pkg::cfg_t                          cfg
);

    cps_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_duration_ms    <= cps_pkg::RESET_RUN_DURATION;
            cfg_reg.lockout_ms         <= cps_pkg::RESET_LOCKOUT;
            cfg_reg.window_start_hour  <= cps_pkg::RESET_WINDOW_START;
            cfg_reg.window_end_hour    <= cps_pkg::RESET_WINDOW_END;
            cfg_reg.day_start_hour     <= cps_pkg::RESET_DAY_START;
            cfg_reg.hygiene_interval_s <= cps_pkg::RESET_HYGIENE_INTVL;
        end
        else if (wr_en)
        begin
            case (wr_index)
                cps_pkg::REG_RUN_DURATION:
                    cfg_reg.run_duration_ms <= wr_data[cps_pkg::MS_W-1:0];
                cps_pkg::REG_LOCKOUT:
                    cfg_reg.lockout_ms <= wr_data[cps_pkg::MS_W-1:0];
                cps_pkg::REG_WINDOW_START:
                    cfg_reg.window_start_hour <= wr_data[cps_pkg::HOUR_W-1:0];
                cps_pkg::REG_WINDOW_END:
                    cfg_reg.window_end_hour <= wr_data[cps_pkg::HOUR_W-1:0];
                cps_pkg::REG_DAY_START:
                    cfg_reg.day_start_hour <= wr_data[cps_pkg::HOUR_W-1:0];
                cps_pkg::REG_HYGIENE_INTVL:
                    cfg_reg.hygiene_interval_s <= wr_data[cps_pkg::INTVL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ src/cps_core.sv @@
// Controller state and the per-beat next-state and result logic.
`default_nettype none
module cps_core
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            commit,
    input  wire cps_pkg::item_t  item,
    input  wire cps_pkg::cfg_t   cfg,
    output cps_pkg::result_t     result
);

    cps_pkg::mode_t                 mode_reg, mode_next;
    logic [31:0]                    entry_ms_reg, entry_ms_next;
    logic [31:0]                    last_end_s_reg, last_end_s_next;
    logic [cps_pkg::DAY_W-1:0]      done_day_reg, done_day_next;
    logic                           done_valid_reg, done_valid_next;
    logic                           sync_reg, sync_next;
    logic                           run_pend_reg, run_pend_next;
    logic                           stop_pend_reg, stop_pend_next;

    logic [31:0] ms_elapsed;
    logic [32:0] s_elapsed;
    logic        run_expired;
    logic        lock_expired;
    logic        hygiene_due;
    logic        sync_now;
    logic        in_window;
    logic        daily_due;
    logic        accepted;
    logic        started;
    logic        stopped;

    assign ms_elapsed   = item.mono_ms - entry_ms_reg;
    assign run_expired  = ms_elapsed >= {5'd0, cfg.run_duration_ms};
    assign lock_expired = ms_elapsed >= {5'd0, cfg.lockout_ms};
    assign s_elapsed    = {1'b0, item.wall_seconds} - {1'b0, last_end_s_reg};
    assign hygiene_due  = (last_end_s_reg != 32'd0) && !s_elapsed[32]
                          && (s_elapsed[31:0] >= {12'd0, cfg.hygiene_interval_s});
    assign sync_now     = sync_reg || item.clock_synced;
    assign in_window    = (item.hour >= cfg.window_start_hour)
                          && (item.hour < cfg.window_end_hour);
    assign daily_due    = (item.hour == cfg.day_start_hour)
                          && !(done_valid_reg && (done_day_reg == item.day_of_year));

    always_comb
    begin
        mode_next       = mode_reg;
        entry_ms_next   = entry_ms_reg;
        last_end_s_next = last_end_s_reg;
        done_day_next   = done_day_reg;
        done_valid_next = done_valid_reg;
        sync_next       = sync_reg;
        run_pend_next   = run_pend_reg;
        stop_pend_next  = stop_pend_reg;
        accepted        = 1'b0;
        started         = 1'b0;
        stopped         = 1'b0;

        case (item.kind)
            cps_pkg::KIND_TICK:
            begin
                if (stop_pend_reg)
                begin
                    stop_pend_next = 1'b0;
                    if (mode_reg == cps_pkg::MODE_RUN)
                    begin
                        mode_next       = cps_pkg::MODE_LOCK;
                        entry_ms_next   = item.mono_ms;
                        last_end_s_next = item.wall_seconds;
                        stopped         = 1'b1;
                    end
                end
                else if (mode_reg == cps_pkg::MODE_RUN)
                begin
                    if (run_expired)
                    begin
                        mode_next       = cps_pkg::MODE_LOCK;
                        entry_ms_next   = item.mono_ms;
                        last_end_s_next = item.wall_seconds;
                        stopped         = 1'b1;
                    end
                end
                else if (mode_reg == cps_pkg::MODE_LOCK)
                begin
                    if (lock_expired)
                    begin
                        mode_next     = cps_pkg::MODE_IDLE;
                        entry_ms_next = item.mono_ms;
                    end
                end
                else if (run_pend_reg)
                begin
                    run_pend_next = 1'b0;
                    mode_next     = cps_pkg::MODE_RUN;
                    entry_ms_next = item.mono_ms;
                    started       = 1'b1;
                end
                else
                begin
                    sync_next = sync_now;
                    if (sync_now)
                    begin
                        if (!in_window)
                        begin
                            if (item.hour == '0)
                            begin
                                done_valid_next = 1'b0;
                            end
                        end
                        else if (daily_due)
                        begin
                            done_day_next   = item.day_of_year;
                            done_valid_next = 1'b1;
                            mode_next       = cps_pkg::MODE_RUN;
                            entry_ms_next   = item.mono_ms;
                            started         = 1'b1;
                        end
                        else if (hygiene_due)
                        begin
                            mode_next     = cps_pkg::MODE_RUN;
                            entry_ms_next = item.mono_ms;
                            started       = 1'b1;
                        end
                    end
                end
            end
            cps_pkg::KIND_RUN_REQ:
            begin
                if (mode_reg != cps_pkg::MODE_LOCK)
                begin
                    run_pend_next = 1'b1;
                    accepted      = 1'b1;
                end
            end
            cps_pkg::KIND_STOP_REQ:
            begin
                stop_pend_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= cps_pkg::MODE_IDLE;
            entry_ms_reg   <= '0;
            last_end_s_reg <= '0;
            done_day_reg   <= '0;
            done_valid_reg <= 1'b0;
            sync_reg       <= 1'b0;
            run_pend_reg   <= 1'b0;
            stop_pend_reg  <= 1'b0;
        end
        else if (commit)
        begin
            mode_reg       <= mode_next;
            entry_ms_reg   <= entry_ms_next;
            last_end_s_reg <= last_end_s_next;
            done_day_reg   <= done_day_next;
            done_valid_reg <= done_valid_next;
            sync_reg       <= sync_next;
            run_pend_reg   <= run_pend_next;
            stop_pend_reg  <= stop_pend_next;
        end
    end

    assign result.request_accepted = accepted;
    assign result.pump_on          = (mode_next == cps_pkg::MODE_RUN);
    assign result.mode             = mode_next;
    assign result.run_started      = started;
    assign result.run_stopped      = stopped;

endmodule
`default_nettype wire

@@ src/circulation_pump_scheduler_top.sv @@
// Top level of the circulation pump scheduler: beat registers, config port and core.
//
// The scheduler takes one beat per item on the s_axis channel: a tick (which
// carries the time of day) or a run or stop request, selected by s_axis_tuser.
// Every input beat produces exactly one result beat on m_axis with the
// request acknowledgment, pump drive, controller mode and run start/stop flags.
// A beat is registered at the input, evaluated combinationally by the controller
// logic and captured in the result register, which offers it as the result beat.
// One beat per cycle is sustained while m_axis_tready is high; the controller
// state update is combinational logic of compares and subtractions.
// When m_axis_tready is low, the result register holds its beat, the input
// register fills and then s_axis_tready drops; nothing is lost or repeated.
// The configuration channel writes one register per beat (index 0 run
// duration, 1 lockout, 2 window start, 3 window end, 4 day start hour,
// 5 hygiene interval) and is always ready; write it only while idle.
// Reset clears the controller to idle, with no requests pending, no clock
// sync seen and the configuration registers at their default values.
`default_nettype none
module circulation_pump_scheduler_top
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // Fields from bit 0: mono_ms[31:0], wall_seconds[63:32], hour[68:64],
    // day_of_year[77:69], clock_synced[78], unused[79].
    input  wire logic [cps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0: kind[1:0].
    input  wire logic [1:0]                        s_axis_tuser,
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // Fields from bit 0: request_accepted[0], pump_on[1], mode[3:2],
    // run_started[4], run_stopped[5], zero fill[7:6].
    output      logic [cps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [cps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [cps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    cps_pkg::cfg_t    cfg;
    cps_pkg::item_t   item_reg;
    cps_pkg::result_t result;
    cps_pkg::result_t result_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             in_take;

    assign cfg_ready = 1'b1;

    cps_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.kind         <= s_axis_tuser;
            item_reg.mono_ms      <= s_axis_tdata[31:0];
            item_reg.wall_seconds <= s_axis_tdata[63:32];
            item_reg.hour         <= s_axis_tdata[68:64];
            item_reg.day_of_year  <= s_axis_tdata[77:69];
            item_reg.clock_synced <= s_axis_tdata[78];
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    cps_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            result_reg.run_stopped,
                            result_reg.run_started,
                            result_reg.mode,
                            result_reg.pump_on,
                            result_reg.request_accepted};

endmodule
`default_nettype wire
